@@ rtl/wcpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcpe_pkg
// Shared types and fixed constants of the window co-occurrence pair emitter.
// ----------------------------------------------------------------------------
package wcpe_pkg;

  // Token and register widths
  localparam int TOKEN_W   = 16;
  localparam int WSIZE_W   = 5;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd5;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_APPEND = 5'b00010,
    S_CENTER = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FLUSH  = 5'b10000
  } state_t;

  // One candidate pair waiting for its successor
  typedef struct packed {
    logic               valid;
    logic [TOKEN_W-1:0] small_tok;
    logic [TOKEN_W-1:0] large_tok;
  } pair_t;

endpackage

@@ rtl/wcpe_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcpe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wcpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data; hold it when no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/window_cooccurrence_pair_emitter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_cooccurrence_pair_emitter_core
// Keeps a sliding window of tokens in a circular RAM and, for each token
// taken, emits every (smaller, larger) pair of the centre token with a
// differing context token, oldest first, flagging the last pair.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ------------------------------------
//   input     in_valid / in_stall    token
//   output    out_valid / out_stall  smaller_token, larger_token, last_pair
//   config    cfg_we                 cfg_wdata (context span)
//
// A transaction is taken in idle; then come the append, the centre read, the
// first read, one scan step per window entry (fill after the append, up to
// 2W+1) and a closing state; the next transaction waits for idle. The single
// RAM read port walks the window one entry per cycle unless the output stalls.
// A stalled output pauses the walk when a second pair is ready and holds the
// closing state until the last pair is taken.
// Reset (rst, synchronous) empties the window and sets the context span to 5;
// RAM contents need no clearing, only entries inside the window are read.
// ----------------------------------------------------------------------------
module window_cooccurrence_pair_emitter_core
  import wcpe_pkg::*;
#(
  parameter int MAX_WINDOW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TOKEN_W-1:0] token,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TOKEN_W-1:0] smaller_token,
  output logic [TOKEN_W-1:0] larger_token,
  output logic               last_pair,
  input  logic               cfg_we,
  input  logic [WSIZE_W-1:0] cfg_wdata
);

  localparam int DEPTH  = 2 * MAX_WINDOW + 1;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int EFF_W  = $clog2(MAX_WINDOW + 1);

  // Fold a sum of two in-range values back into the RAM address range
  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
    return r[PTR_W-1:0];
  endfunction

  state_t               state, state_next;
  logic [WSIZE_W-1:0]   ctx_span;
  logic [TOKEN_W-1:0]   tok;
  logic [PTR_W-1:0]     head;
  logic [FILL_W-1:0]    fill;
  logic [FILL_W-1:0]    idx;
  logic [TOKEN_W-1:0]   ctok;
  pair_t                pend;

  logic [EFF_W-1:0]     eff;
  logic [FILL_W-1:0]    cap;
  logic                 full;
  logic [PTR_W-1:0]     head1;
  logic [FILL_W-1:0]    fill1, fill2;
  logic                 over;
  logic [PTR_W-1:0]     head_next;
  logic [FILL_W-1:0]    fill_next;
  logic [FILL_W-1:0]    center;

  logic                 ram_we, ram_re;
  logic [PTR_W-1:0]     ram_waddr, ram_raddr;
  logic [TOKEN_W-1:0]   rdata;

  logic                 qual, free, go, last_idx;
  logic                 push, push_last;
  logic [TOKEN_W-1:0]   push_small, push_large;

  // Window RAM
  wcpe_ram #(
    .WIDTH (TOKEN_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tok),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Effective window size and capacity
  always_comb begin
    if (ctx_span == '0) begin
      eff = EFF_W'(1);
    end else if (32'(ctx_span) > 32'(MAX_WINDOW)) begin
      eff = EFF_W'(MAX_WINDOW);
    end else begin
      eff = EFF_W'(ctx_span);
    end
    cap = FILL_W'({eff, 1'b1});
  end

  // Append: drop oldest if the store is full, then trim to capacity
  always_comb begin
    full      = (fill == FILL_W'(DEPTH));
    head1     = full ? wrap(SUM_W'(head) + SUM_W'(1)) : head;
    fill1     = full ? FILL_W'(DEPTH - 1) : fill;
    ram_waddr = wrap(SUM_W'(head1) + SUM_W'(fill1));
    fill2     = fill1 + FILL_W'(1);
    over      = (fill2 > cap);
    head_next = over ? wrap(SUM_W'(head1) + SUM_W'(fill2 - cap)) : head1;
    fill_next = over ? cap : fill2;
  end

  assign center = fill >> 1;

  // Scan decisions on the entry whose data sits on the RAM output
  always_comb begin
    free     = !out_valid || !out_stall;
    qual     = (idx != center) && (rdata != ctok);
    go       = !(qual && pend.valid) || free;
    last_idx = (idx == fill - FILL_W'(1));
  end

  // RAM control and output pushes
  always_comb begin
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = head;
    push       = 1'b0;
    push_last  = 1'b0;
    push_small = pend.small_tok;
    push_large = pend.large_tok;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        ram_we     = 1'b1;
        state_next = S_CENTER;
      end
      S_CENTER: begin
        ram_re     = 1'b1;
        ram_raddr  = wrap(SUM_W'(head) + SUM_W'(center));
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (idx == '1) begin
          // first scan cycle: centre data present, issue oldest entry read
          ram_re    = 1'b1;
          ram_raddr = head;
        end else if (go) begin
          push = qual && pend.valid;
          if (last_idx) begin
            state_next = S_FLUSH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = wrap(SUM_W'(head) + SUM_W'(idx) + SUM_W'(1));
          end
        end
      end
      S_FLUSH: begin
        if (!pend.valid) begin
          state_next = S_IDLE;
        end else if (free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // Sequencer, window pointers, pending pair and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ctx_span    <= WSIZE_RESET;
      head        <= '0;
      fill        <= '0;
      pend.valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        ctx_span <= cfg_wdata;
      end
      if (state == S_APPEND) begin
        head <= head_next;
        fill <= fill_next;
      end
      // Hold the newest qualifying pair until the next one or the end
      if (state == S_APPEND) begin
        pend.valid <= 1'b0;
      end else if (state == S_SCAN && idx != '1 && go && qual) begin
        pend.valid <= 1'b1;
      end else if (state == S_FLUSH && free) begin
        pend.valid <= 1'b0;
      end
      if (state == S_SCAN && idx != '1 && go && qual) begin
        pend.small_tok <= (rdata < ctok) ? rdata : ctok;
        pend.large_tok <= (rdata < ctok) ? ctok : rdata;
      end
      // Output register
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      tok <= token;
    end
    if (state == S_CENTER) begin
      idx <= '1;
    end else if (state == S_SCAN) begin
      if (idx == '1) begin
        ctok <= rdata;
        idx  <= '0;
      end else if (go && !last_idx) begin
        idx <= idx + FILL_W'(1);
      end
    end
    if (push) begin
      smaller_token <= push_small;
      larger_token  <= push_large;
      last_pair     <= push_last;
    end
  end

  // Window never grows past the store
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("window fill beyond store depth");

  // A push never overwrites a result still held by the receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(push && out_valid && out_stall))
    else $error("output register overwritten while stalled");

  // No transaction accepted while a pair is still pending
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !pend.valid)
    else $error("input accepted with pair pending");

  // Each pair that raises out_valid is strictly ordered
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (smaller_token < larger_token))
    else $error("emitted pair not ordered");

endmodule
